// ===== hdl/kronecker_leverage_row_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Kronecker leverage row sampler
// Shared concurrent assertion forms used by the RTL files of the block.
// ----------------------------------------------------------------------------
`ifndef KRONECKER_LEVERAGE_ROW_SAMPLER_MACROS_SVH
`define KRONECKER_LEVERAGE_ROW_SAMPLER_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define KLRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// The consequence must hold in the cycle after the antecedent.
`define KLRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle");

`endif

// ===== hdl/klrs_pkg.sv =====
// ----------------------------------------------------------------------------
// klrs_pkg
// Types and constants shared by the Kronecker leverage row sampler.
// ----------------------------------------------------------------------------
package klrs_pkg;

  localparam int NUM_FACTORS  = 4;
  localparam int FACT_BITS    = 2;
  localparam int ROW_BITS     = 10;
  localparam int MAX_ROWS     = 1024;
  localparam int ROWCNT_BITS  = 11;
  localparam int FRAC_BITS    = 32;
  localparam int MASS_BITS    = 48;
  localparam int DROWS_BITS   = 21;
  localparam int RIDGE_BITS   = 20;
  localparam int NFC_BITS     = 3;
  localparam int Z_BITS       = 49;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 48;
  localparam int DIV_TOP      = FRAC_BITS + 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGINAL_MASS  = 3'd0,
    REG_AUGMENTED_ROWS = 3'd1,
    REG_FACTOR_COUNT   = 3'd2,
    REG_ROWS_A         = 3'd3,
    REG_ROWS_B         = 3'd4,
    REG_ROWS_C         = 3'd5,
    REG_ROWS_D         = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                   start;
    logic [FRAC_BITS-1:0]   uniform;
    logic [ROWCNT_BITS-1:0] rows;
  } lane_cmd_t;

  typedef struct packed {
    logic                 busy;
    logic [ROW_BITS-1:0]  idx;
    logic [FRAC_BITS-1:0] step;
  } lane_status_t;

endpackage

// ===== hdl/klrs_ram.sv =====
// ----------------------------------------------------------------------------
// klrs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module klrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/klrs_lane.sv =====
// ----------------------------------------------------------------------------
// klrs_lane
// One factor lane: holds its CDF table and binary-searches a uniform in it.
// ----------------------------------------------------------------------------
`include "kronecker_leverage_row_sampler_macros.svh"

module klrs_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  klrs_pkg::lane_cmd_t                  cmd,
  input  logic                                 wr_en,
  input  logic [klrs_pkg::ROW_BITS-1:0]        wr_row,
  input  logic [klrs_pkg::FRAC_BITS-1:0]       wr_data,
  output klrs_pkg::lane_status_t               status
);

  typedef enum logic [2:0] {L_IDLE, L_SEARCH, L_CMP, L_CUR, L_PREV} lane_state_t;

  lane_state_t                            state_r;
  logic [klrs_pkg::ROWCNT_BITS-1:0]       lo_r, hi_r, rows_r;
  logic [klrs_pkg::FRAC_BITS-1:0]         u_r, cur_r, step_r, rdata;
  logic [klrs_pkg::ROW_BITS-1:0]          idx_r, raddr, clamp_idx;
  logic [klrs_pkg::ROWCNT_BITS:0]         sum;
  logic [klrs_pkg::ROWCNT_BITS-1:0]       mid, clamp_full;

  assign sum        = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = sum[klrs_pkg::ROWCNT_BITS:1];
  assign clamp_full = (lo_r >= rows_r) ? (rows_r - 1'b1) : lo_r;
  assign clamp_idx  = clamp_full[klrs_pkg::ROW_BITS-1:0];

  always_comb begin
    case (state_r)
      L_SEARCH: raddr = (lo_r < hi_r) ? mid[klrs_pkg::ROW_BITS-1:0] : clamp_idx;
      L_CUR:    raddr = idx_r - 1'b1;
      default:  raddr = mid[klrs_pkg::ROW_BITS-1:0];
    endcase
  end

  klrs_ram #(
    .WIDTH(klrs_pkg::FRAC_BITS),
    .DEPTH(klrs_pkg::MAX_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_row),
    .wdata(wr_data),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      unique case (state_r)
        L_IDLE: begin
          if (cmd.start) begin
            u_r     <= cmd.uniform;
            rows_r  <= cmd.rows;
            lo_r    <= '0;
            hi_r    <= cmd.rows;
            state_r <= L_SEARCH;
          end
        end
        L_SEARCH: begin
          if (lo_r < hi_r) begin
            state_r <= L_CMP;
          end else begin
            idx_r   <= clamp_idx;
            state_r <= L_CUR;
          end
        end
        L_CMP: begin
          if (rdata > u_r) begin
            hi_r <= mid;
          end else begin
            lo_r <= mid + 1'b1;
          end
          state_r <= L_SEARCH;
        end
        L_CUR: begin
          cur_r <= rdata;
          if (idx_r == '0) begin
            step_r  <= rdata;
            state_r <= L_IDLE;
          end else begin
            state_r <= L_PREV;
          end
        end
        L_PREV: begin
          step_r  <= (cur_r >= rdata) ? (cur_r - rdata) : '0;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign status.busy = (state_r != L_IDLE);
  assign status.idx  = idx_r;
  assign status.step = step_r;

  `KLRS_ASSERT_NOW(a_lane_cmp_range, clk, rst_n, state_r == L_CMP, lo_r < hi_r)
  `KLRS_ASSERT_NEXT(a_lane_start, clk, rst_n, cmd.start && state_r == L_IDLE, state_r == L_SEARCH)
  `KLRS_ASSERT_NEXT(a_lane_cmp_back, clk, rst_n, state_r == L_CMP, state_r == L_SEARCH)

endmodule

// ===== hdl/klrs_div.sv =====
// ----------------------------------------------------------------------------
// klrs_div
// Bit-serial restoring divider giving floor(2^48 / z), saturated to 32 bits.
// ----------------------------------------------------------------------------
module klrs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [klrs_pkg::Z_BITS-1:0]     z,
  output logic                            busy,
  output logic [klrs_pkg::FRAC_BITS-1:0]  quot
);

  localparam int CNT_BITS = $clog2(klrs_pkg::DIV_TOP + 1);

  logic                            busy_r;
  logic [CNT_BITS-1:0]             cnt_r;
  logic [klrs_pkg::Z_BITS-1:0]     z_r, rem_r;
  logic [klrs_pkg::FRAC_BITS:0]    q_r;
  logic [klrs_pkg::Z_BITS:0]       trial;
  logic                            qbit;

  assign trial = {rem_r, (cnt_r == CNT_BITS'(klrs_pkg::DIV_TOP))};
  assign qbit  = (trial >= {1'b0, z_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(klrs_pkg::DIV_TOP);
      z_r    <= z;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? klrs_pkg::Z_BITS'(trial - {1'b0, z_r})
                    : trial[klrs_pkg::Z_BITS-1:0];
      q_r   <= {q_r[klrs_pkg::FRAC_BITS-1:0], qbit};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r[klrs_pkg::FRAC_BITS] ? '1 : q_r[klrs_pkg::FRAC_BITS-1:0];

endmodule

// ===== hdl/kronecker_leverage_row_sampler.sv =====
// ----------------------------------------------------------------------------
// kronecker_leverage_row_sampler
// Inverse-transform sampler for rows of an augmented Kronecker design matrix.
// ----------------------------------------------------------------------------
// Input transfers carry either a load (func 0), which writes one Q0.32 CDF
// entry into the table of one factor lane, or a sample (func 1). A load
// gives no result. A sample runs one item at a time: a coin multiply step and
// a compare step, then either the four factor lanes search in parallel, each
// with a read and a compare step per probe of its table's RAM, followed by a
// probability product over the factors in use, or the ridge path, which waits
// for the bit-serial divider for 1/Z. The next input transfer can come once
// the result is registered. Results leave through an output register; the
// next item is accepted while a result waits, and a finished result waits
// for the register when the receiver stalls. The configuration port is
// always ready and must be written only while the block is idle. Reset
// restores the register defaults; CDF tables hold nothing valid until loaded.
// ----------------------------------------------------------------------------
`include "kronecker_leverage_row_sampler_macros.svh"

module kronecker_leverage_row_sampler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic [1:0]                            in_load_factor,
  input  logic [klrs_pkg::ROW_BITS-1:0]         in_load_row,
  input  logic [31:0]                           in_load_cdf,
  input  logic [31:0]                           in_coin_uniform,
  input  logic [31:0]                           in_uniform_a,
  input  logic [31:0]                           in_uniform_b,
  input  logic [31:0]                           in_uniform_c,
  input  logic [31:0]                           in_uniform_d,
  input  logic [31:0]                           in_ridge_uniform,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_is_ridge,
  output logic [klrs_pkg::ROW_BITS-1:0]         out_row_a,
  output logic [klrs_pkg::ROW_BITS-1:0]         out_row_b,
  output logic [klrs_pkg::ROW_BITS-1:0]         out_row_c,
  output logic [klrs_pkg::ROW_BITS-1:0]         out_row_d,
  output logic [klrs_pkg::RIDGE_BITS-1:0]       out_ridge_row,
  output logic [31:0]                           out_probability,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [klrs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [klrs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int NF = klrs_pkg::NUM_FACTORS;
  localparam int FB = klrs_pkg::FRAC_BITS;
  localparam int RB = klrs_pkg::ROWCNT_BITS;
  localparam int DB = klrs_pkg::DROWS_BITS;
  localparam int ZB = klrs_pkg::Z_BITS;
  localparam int KB = klrs_pkg::FACT_BITS + 1;

  typedef enum logic [2:0] {
    T_IDLE, T_MUL, T_CMP, T_SEARCH, T_PROD, T_RIDGE, T_OUT
  } top_state_t;

  top_state_t                      state_r;
  logic [klrs_pkg::MASS_BITS-1:0]  mass_r;
  logic [DB-1:0]                   drows_r, d_c;
  logic [klrs_pkg::NFC_BITS-1:0]   nfc_r, nf_c;
  logic [RB-1:0]                   rows_r [NF];
  logic [RB-1:0]                   rows_c [NF];
  logic [FB-1:0]                   u_r [NF];
  logic [FB-1:0]                   coin_r, ridge_u_r, prob_r;
  logic [2*FB-1:0]                 plo_r, prod_full;
  logic [ZB-FB+FB-1:0]             phi_r;
  logic [FB+DB-1:0]                rprod_r;
  logic [ZB-1:0]                   z;
  logic [ZB+1:0]                   midv;
  logic                            orig;
  logic [DB-1:0]                   rrow, rrow_c;
  logic [klrs_pkg::RIDGE_BITS-1:0] ridge_row_r;
  logic                            is_ridge_r;
  logic [KB-1:0]                   k_r;
  logic                            any_busy;
  logic                            in_xfer, sample_xfer, div_busy;
  logic [FB-1:0]                   div_quot;
  logic [FB-1:0]                   in_u [NF];
  logic [NF-1:0]                   lane_busy;

  logic                            out_valid_r, out_is_ridge_r;
  logic [klrs_pkg::ROW_BITS-1:0]   out_row_r [NF];
  logic [klrs_pkg::RIDGE_BITS-1:0] out_ridge_row_r;
  logic [FB-1:0]                   out_prob_r;

  klrs_pkg::lane_cmd_t             lane_cmd [NF];
  klrs_pkg::lane_status_t          lane_st  [NF];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r  <= klrs_pkg::MASS_BITS'(65536);
      drows_r <= DB'(1);
      nfc_r   <= klrs_pkg::NFC_BITS'(1);
      for (int i = 0; i < NF; i++) begin
        rows_r[i] <= RB'(1);
      end
    end else if (cfg_valid) begin
      unique case (klrs_pkg::cfg_reg_t'(cfg_index))
        klrs_pkg::REG_ORIGINAL_MASS:  mass_r   <= cfg_data;
        klrs_pkg::REG_AUGMENTED_ROWS: drows_r  <= cfg_data[DB-1:0];
        klrs_pkg::REG_FACTOR_COUNT:   nfc_r    <= cfg_data[klrs_pkg::NFC_BITS-1:0];
        klrs_pkg::REG_ROWS_A:         rows_r[0] <= cfg_data[RB-1:0];
        klrs_pkg::REG_ROWS_B:         rows_r[1] <= cfg_data[RB-1:0];
        klrs_pkg::REG_ROWS_C:         rows_r[2] <= cfg_data[RB-1:0];
        klrs_pkg::REG_ROWS_D:         rows_r[3] <= cfg_data[RB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (drows_r == '0) begin
      d_c = DB'(1);
    end else if (drows_r > DB'(1048576)) begin
      d_c = DB'(1048576);
    end else begin
      d_c = drows_r;
    end
    if (nfc_r == '0) begin
      nf_c = klrs_pkg::NFC_BITS'(1);
    end else if (nfc_r > klrs_pkg::NFC_BITS'(NF)) begin
      nf_c = klrs_pkg::NFC_BITS'(NF);
    end else begin
      nf_c = nfc_r;
    end
    for (int i = 0; i < NF; i++) begin
      if (rows_r[i] == '0) begin
        rows_c[i] = RB'(1);
      end else if (rows_r[i] > RB'(klrs_pkg::MAX_ROWS)) begin
        rows_c[i] = RB'(klrs_pkg::MAX_ROWS);
      end else begin
        rows_c[i] = rows_r[i];
      end
    end
  end

  assign z    = {1'b0, mass_r} + (ZB'(d_c) << 16);
  assign midv = (ZB+2)'(plo_r[2*FB-1:FB]) + (ZB+2)'(phi_r);
  assign orig = (midv < (ZB+2)'(mass_r)) ||
                ((midv == (ZB+2)'(mass_r)) && (plo_r[FB-1:0] == '0));
  assign rrow   = rprod_r[FB+DB-1:FB];
  assign rrow_c = (rrow >= d_c) ? (d_c - 1'b1) : rrow;
  assign prod_full = prob_r * lane_st[k_r[KB-2:0]].step;

  assign in_ready    = (state_r == T_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign sample_xfer = in_xfer && in_func;

  assign in_u[0] = in_uniform_a;
  assign in_u[1] = in_uniform_b;
  assign in_u[2] = in_uniform_c;
  assign in_u[3] = in_uniform_d;

  for (genvar g = 0; g < NF; g++) begin : g_lane
    assign lane_cmd[g].start   = (state_r == T_CMP) && orig;
    assign lane_cmd[g].uniform = u_r[g];
    assign lane_cmd[g].rows    = rows_c[g];
    assign lane_busy[g]        = lane_st[g].busy;

    klrs_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd[g]),
      .wr_en  (in_xfer && !in_func && (in_load_factor == klrs_pkg::FACT_BITS'(g))),
      .wr_row (in_load_row),
      .wr_data(in_load_cdf),
      .status (lane_st[g])
    );
  end

  assign any_busy = |lane_busy;

  klrs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start((state_r == T_CMP) && !orig),
    .z    (z),
    .busy (div_busy),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != T_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_IDLE: begin
          if (sample_xfer) begin
            coin_r    <= in_coin_uniform;
            ridge_u_r <= in_ridge_uniform;
            for (int i = 0; i < NF; i++) begin
              u_r[i] <= in_u[i];
            end
            state_r <= T_MUL;
          end
        end
        T_MUL: begin
          plo_r   <= z[FB-1:0] * coin_r;
          phi_r   <= z[ZB-1:FB] * coin_r;
          rprod_r <= ridge_u_r * d_c;
          state_r <= T_CMP;
        end
        T_CMP: begin
          if (orig) begin
            state_r <= T_SEARCH;
          end else begin
            ridge_row_r <= rrow_c[klrs_pkg::RIDGE_BITS-1:0];
            state_r     <= T_RIDGE;
          end
        end
        T_SEARCH: begin
          if (!any_busy) begin
            prob_r     <= lane_st[0].step;
            k_r        <= KB'(1);
            is_ridge_r <= 1'b0;
            state_r    <= T_PROD;
          end
        end
        T_PROD: begin
          if (k_r < KB'(nf_c)) begin
            prob_r <= prod_full[2*FB-1:FB];
            k_r    <= k_r + 1'b1;
          end else begin
            state_r <= T_OUT;
          end
        end
        T_RIDGE: begin
          if (!div_busy) begin
            prob_r     <= div_quot;
            is_ridge_r <= 1'b1;
            state_r    <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_is_ridge_r  <= is_ridge_r;
            out_prob_r      <= prob_r;
            out_ridge_row_r <= is_ridge_r ? ridge_row_r : '0;
            for (int i = 0; i < NF; i++) begin
              out_row_r[i] <= (!is_ridge_r && (KB'(i) < KB'(nf_c))) ? lane_st[i].idx : '0;
            end
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_ridge    = out_is_ridge_r;
  assign out_row_a       = out_row_r[0];
  assign out_row_b       = out_row_r[1];
  assign out_row_c       = out_row_r[2];
  assign out_row_d       = out_row_r[3];
  assign out_ridge_row   = out_ridge_row_r;
  assign out_probability = out_prob_r;

  `KLRS_ASSERT_NEXT(a_sample_holds_input, clk, rst_n, sample_xfer, !in_ready)
  `KLRS_ASSERT_NOW(a_ridge_rows_zero, clk, rst_n, out_valid && out_is_ridge, (out_row_a == '0) && (out_row_b == '0) && (out_row_c == '0) && (out_row_d == '0))
  `KLRS_ASSERT_NOW(a_orig_ridge_zero, clk, rst_n, out_valid && !out_is_ridge, out_ridge_row == '0)

endmodule
